/* hdl/rdiv_pkg.sv */
// rdiv_pkg: shared constants for the restoring divider
// no dependencies; used by the channel interfaces and restoring_divider, not by rdiv_cell
package rdiv_pkg;

  // width of the dividend, divisor, quotient and remainder fields on the channels
  localparam int unsigned FIELD_W = 32;

endpackage : rdiv_pkg

/* hdl/rdiv_if.sv */
// rdiv_if: valid/ready channel interfaces for operand and result beats
// depends on rdiv_pkg for the field width
interface rdiv_in_if;
  logic                          valid;
  logic                          ready;
  logic [rdiv_pkg::FIELD_W-1:0]  dividend;
  logic [rdiv_pkg::FIELD_W-1:0]  divisor;

  modport source (output valid, dividend, divisor, input ready);
  modport sink   (input valid, dividend, divisor, output ready);
endinterface : rdiv_in_if

interface rdiv_out_if;
  logic                          valid;
  logic                          ready;
  logic [rdiv_pkg::FIELD_W-1:0]  quotient;
  logic [rdiv_pkg::FIELD_W-1:0]  remainder;
  logic                          divide_by_zero;

  modport source (output valid, quotient, remainder, divide_by_zero, input ready);
  modport sink   (input valid, quotient, remainder, divide_by_zero, output ready);
endinterface : rdiv_out_if

/* hdl/rdiv_cell.sv */
// rdiv_cell: one shift / trial-subtract / restore step with its own stage register
// no package dependencies; chained WIDTH times by restoring_divider
module rdiv_cell #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_part,
  input  logic [WIDTH-1:0] in_quo,
  input  logic [WIDTH-1:0] in_den,
  input  logic             in_dz,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_part,
  output logic [WIDTH-1:0] out_quo,
  output logic [WIDTH-1:0] out_den,
  output logic             out_dz
);

  logic             valid;
  logic [WIDTH-1:0] part;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] den;
  logic             dz;

  logic [WIDTH-1:0] part_sh;
  logic [WIDTH+1:0] diff;
  logic             fits;
  logic [WIDTH-1:0] part_next;
  logic [WIDTH-1:0] quo_next;
  logic             accept;

  // stage can take a beat when empty or when its beat moves on
  assign in_ready = !valid || out_ready;
  assign accept   = in_valid && in_ready;

  // bring the next dividend bit in from the top of the quotient word
  assign part_sh = {in_part[WIDTH-2:0], in_quo[WIDTH-1]};
  // widened trial difference; the top bit is the borrow
  assign diff = {1'b0, in_part[WIDTH-1], part_sh} - {2'b00, in_den};
  assign fits = !diff[WIDTH+1];

  assign part_next = fits ? diff[WIDTH-1:0] : part_sh;
  assign quo_next  = {in_quo[WIDTH-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      part <= part_next;
      quo  <= quo_next;
      den  <= in_den;
      dz   <= in_dz;
    end
  end

  assign out_valid = valid;
  assign out_part  = part;
  assign out_quo   = quo;
  assign out_den   = den;
  assign out_dz    = dz;

endmodule : rdiv_cell

/* hdl/restoring_divider.sv */
// restoring_divider: pipelined unsigned restoring divider, one cell per quotient bit
// depends on rdiv_pkg, rdiv_in_if / rdiv_out_if and rdiv_cell
//
// usage
//   operands : sink channel, one beat carries a dividend and a divisor
//   results  : source channel, one beat carries quotient, remainder and
//              divide_by_zero for each operand beat, in arrival order
//   a row of WIDTH identical cells, each does one shift / trial-subtract /
//   restore step and registers its partial remainder, quotient bits and divisor
//   each operand beat moves through the cells in row order, and the last cell's
//   register holds the result beat until results.ready takes it
//   throughput: one beat per cycle while results.ready is high, set by the single step in each cell
//   a zero divisor gives an all-ones quotient, the dividend as remainder and
//   divide_by_zero set; the cell row produces those values on its own
//   stalls: each cell holds its beat while the next one is full and stalled;
//   empty cells keep filling, so the row holds up to WIDTH beats while a
//   result waits on results.ready
//   reset clears only the per-cell valid bits; payload registers are not reset
//   operands wider than WIDTH are truncated, results are zero-extended or
//   truncated to the 32-bit fields
module restoring_divider #(
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  rdiv_in_if.sink     operands,
  rdiv_out_if.source  results
);

  import rdiv_pkg::*;

  localparam logic [WIDTH-1:0] ALL_ONES = '1;

  // links between neighboring cells; index 0 is the row input
  logic             link_valid [WIDTH+1];
  logic             link_ready [WIDTH+1];
  logic [WIDTH-1:0] link_part  [WIDTH+1];
  logic [WIDTH-1:0] link_quo   [WIDTH+1];
  logic [WIDTH-1:0] link_den   [WIDTH+1];
  logic             link_dz    [WIDTH+1];

  logic [WIDTH-1:0] num_w;
  logic [WIDTH-1:0] den_w;

  // operands to the internal width
  assign num_w = WIDTH'(operands.dividend);
  assign den_w = WIDTH'(operands.divisor);

  // row input: partial remainder starts at zero, the quotient word holds the
  // dividend whose bits shift out as quotient bits shift in
  assign link_valid[0]  = operands.valid;
  assign operands.ready = link_ready[0];
  assign link_part[0]   = '0;
  assign link_quo[0]    = num_w;
  assign link_den[0]    = den_w;
  assign link_dz[0]     = (den_w == '0);

  // the row of cells
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    rdiv_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_part   (link_part[i]),
      .in_quo    (link_quo[i]),
      .in_den    (link_den[i]),
      .in_dz     (link_dz[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_part  (link_part[i+1]),
      .out_quo   (link_quo[i+1]),
      .out_den   (link_den[i+1]),
      .out_dz    (link_dz[i+1])
    );
  end

  // the last cell's register is the output register
  assign link_ready[WIDTH]      = results.ready;
  assign results.valid          = link_valid[WIDTH];
  assign results.quotient       = FIELD_W'(link_quo[WIDTH]);
  assign results.remainder      = FIELD_W'(link_part[WIDTH]);
  assign results.divide_by_zero = link_dz[WIDTH];

  // a zero divisor must leave the row with every quotient bit set
  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.divide_by_zero |-> results.quotient == FIELD_W'(ALL_ONES))
    else $error("divide by zero beat without all-ones quotient");

  // a finished division leaves a remainder below its divisor
  assert property (@(posedge clk) disable iff (rst)
    link_valid[WIDTH] && !link_dz[WIDTH] |-> link_part[WIDTH] < link_den[WIDTH])
    else $error("remainder not below divisor");

  // the zero flag follows the divisor that travels with the beat
  assert property (@(posedge clk) disable iff (rst)
    link_valid[WIDTH] |-> link_dz[WIDTH] == (link_den[WIDTH] == '0))
    else $error("divide by zero flag out of step with divisor");

endmodule : restoring_divider

/* tb/tb_top.sv */
// tb_top: self-checking bench for the pipelined restoring divider
// depends on rdiv_pkg, rdiv_in_if / rdiv_out_if and restoring_divider from hdl
`timescale 1ns / 1ps

module tb_top;
  import rdiv_pkg::*;

  localparam int unsigned DIV_W       = FIELD_W;
  localparam int          NUM_RANDOM  = 1300;
  localparam int          CALM_FROM   = 1150;  // random beats from here on run with no idling
  localparam int          HOLD_AT     = 300;   // random beat that triggers the long result hold
  localparam int          HOLD_CYCLES = 400;
  localparam int          STALL_LIMIT = 4000;  // cycles with no beat on either channel
  localparam int          NUM_ROWS    = 18;

  // one result beat as the bench expects it
  typedef struct packed {
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
    logic             divide_by_zero;
  } quot_rem_t;

  // directed row: operands, and a typed-in answer where it is obvious
  typedef struct packed {
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
    logic             pinned;
    quot_rem_t        want;
  } div_row_t;

  logic clk;
  logic rst;

  rdiv_in_if  op_ch ();
  rdiv_out_if res_ch ();

  restoring_divider #(.WIDTH(DIV_W)) dut (
    .clk      (clk),
    .rst      (rst),
    .operands (op_ch),
    .results  (res_ch)
  );

  // expected beats in issue order, oldest at the front
  quot_rem_t pending_quot_rem [$];
  int        fail_count = 0;

  // shared knobs between the two channel drivers
  bit idle_on       = 1'b0;  // random idling allowed on both sides
  bit long_hold_req = 1'b0;  // ask the result side for one long hold-off

  // extremes, zero divisor, and large operands where a 32-bit partial
  // remainder would lose its sign; unpinned rows go through the predictor
  div_row_t div_rows [NUM_ROWS] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}},
    '{32'h1234_5678, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 32'h1234_5678, 1'b1}},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 32'h0000_0000, 1'b0}},
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'h0000_0001, 1'b0}},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'hFFFF_FFFE, 1'b0}},
    '{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0000_0001, 32'h7FFF_FFFF, 1'b0}},
    '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0002, 32'h0000_0001, 1'b0}},
    '{32'h8000_0000, 32'h8000_0001, 1'b1, '{32'h0000_0000, 32'h8000_0000, 1'b0}},
    '{32'h8000_0000, 32'h0000_0002, 1'b1, '{32'h4000_0000, 32'h0000_0000, 1'b0}},
    '{32'h0000_0007, 32'h0000_0003, 1'b1, '{32'h0000_0002, 32'h0000_0001, 1'b0}},
    '{32'hFFFF_FFF0, 32'h8000_0001, 1'b0, '0},
    '{32'hDEAD_BEEF, 32'hC000_0003, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'h0000_0003, 1'b0, '0},
    '{32'h7FFF_FFFF, 32'h0001_0001, 1'b0, '0},
    '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, '0}
  };

  // predictor: shift, trial subtract, restore with a partial remainder
  // one bit wider than the operands so the sign of the trial is exact
  function automatic quot_rem_t restoring_quot_rem(input logic [DIV_W-1:0] num,
                                                   input logic [DIV_W-1:0] den);
    logic [DIV_W:0]   partial;
    logic [DIV_W:0]   trial;
    logic [DIV_W-1:0] quo;
    quot_rem_t        res;
    int               step;
    if (den == '0) begin
      // zero divisor: all-ones quotient, dividend passes through, flag set
      res.quotient       = '1;
      res.remainder      = num;
      res.divide_by_zero = 1'b1;
      return res;
    end
    partial = '0;
    quo     = num;
    for (step = 0; step < DIV_W; step++) begin
      // bring the next dividend bit in at the bottom of the partial remainder
      partial = {partial[DIV_W-1:0], quo[DIV_W-1]};
      quo     = quo << 1;
      trial   = partial - {1'b0, den};
      // top bit clear means the trial difference is not negative: keep it
      if (!trial[DIV_W]) begin
        partial = trial;
        quo[0]  = 1'b1;
      end
    end
    res.quotient       = quo;
    res.remainder      = partial[DIV_W-1:0];
    res.divide_by_zero = 1'b0;
    return res;
  endfunction

  // operand mix: full random, random bit length, all ones, zero, one,
  // top bit set (large operands), and small values
  function automatic logic [DIV_W-1:0] pick_operand();
    logic [DIV_W-1:0] v;
    v = $urandom();
    case ($urandom_range(0, 7))
      0, 1:    return v;
      2:       return v >> $urandom_range(0, DIV_W - 1);
      3:       return '1;
      4:       return '0;
      5:       return DIV_W'(1);
      6:       return v | (DIV_W'(1) << (DIV_W - 1));
      default: return v & 32'hF;
    endcase
  endfunction

  // ----------------------------------------------------------------------
  // clock and reset
  // ----------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // every input of the block is known from time zero
  initial begin
    rst            = 1'b1;
    op_ch.valid    = 1'b0;
    op_ch.dividend = '0;
    op_ch.divisor  = '0;
    res_ch.ready   = 1'b0;
  end

  // ----------------------------------------------------------------------
  // operand side
  // ----------------------------------------------------------------------
  // offers one operand beat and returns on the edge where it is taken;
  // valid stays high after the beat so back-to-back beats need no second
  // assignment in the same step, and a gap lowers it first
  task automatic offer_operands(input logic [DIV_W-1:0] a,
                                input logic [DIV_W-1:0] b,
                                input quot_rem_t        expected);
    if (idle_on && !long_hold_req && $urandom_range(0, 4) == 0) begin
      op_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    op_ch.valid    <= 1'b1;
    op_ch.dividend <= a;
    op_ch.divisor  <= b;
    do @(posedge clk); while (!op_ch.ready);
    // beat taken at this edge; its result still has the whole cell row ahead
    pending_quot_rem.push_back(expected);
  endtask

  initial begin : operand_feed
    logic [DIV_W-1:0] a;
    logic [DIV_W-1:0] b;
    int               k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows: typed-in answers where pinned, predictor otherwise
    idle_on = 1'b1;
    for (k = 0; k < NUM_ROWS; k++) begin
      if (div_rows[k].pinned)
        offer_operands(div_rows[k].dividend, div_rows[k].divisor, div_rows[k].want);
      else
        offer_operands(div_rows[k].dividend, div_rows[k].divisor,
                       restoring_quot_rem(div_rows[k].dividend, div_rows[k].divisor));
    end

    // random beats
    for (k = 0; k < NUM_RANDOM; k++) begin
      // alternate busy stretches with idling and quiet ones without,
      // and run the tail of the stream flat out
      if (k >= CALM_FROM)
        idle_on = 1'b0;
      else if (k % 64 == 0)
        idle_on = ($urandom_range(0, 2) != 0);
      // one long hold on the result side while operands keep coming,
      // so every cell fills and the operand channel backs up
      if (k == HOLD_AT)
        long_hold_req = 1'b1;
      a = pick_operand();
      case ($urandom_range(0, 9))
        0:       b = a;                             // exact division
        1:       b = a + 1;                         // divisor just above
        default: b = pick_operand();
      endcase
      offer_operands(a, b, restoring_quot_rem(a, b));
    end
    op_ch.valid <= 1'b0;

    // drain, then give the pipe its latency again to catch stray beats
    while (pending_quot_rem.size() != 0) @(posedge clk);
    repeat (DIV_W + 16) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // ----------------------------------------------------------------------
  // result side
  // ----------------------------------------------------------------------
  // one assignment to ready per loop pass, and each pass waits on the clock
  initial begin : result_drain
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        res_ch.ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each result beat with the oldest expectation, field by field
  always @(posedge clk) begin
    quot_rem_t exp_beat;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_quot_rem.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat q=%h r=%h dz=%b", $time,
                 res_ch.quotient, res_ch.remainder, res_ch.divide_by_zero);
      end else begin
        exp_beat = pending_quot_rem.pop_front();
        if (res_ch.quotient !== exp_beat.quotient) begin
          fail_count++;
          $display("%0t: quotient expected %h actual %h", $time,
                   exp_beat.quotient, res_ch.quotient);
        end
        if (res_ch.remainder !== exp_beat.remainder) begin
          fail_count++;
          $display("%0t: remainder expected %h actual %h", $time,
                   exp_beat.remainder, res_ch.remainder);
        end
        if (res_ch.divide_by_zero !== exp_beat.divide_by_zero) begin
          fail_count++;
          $display("%0t: divide_by_zero expected %b actual %b", $time,
                   exp_beat.divide_by_zero, res_ch.divide_by_zero);
        end
      end
    end
  end

  // ----------------------------------------------------------------------
  // watchdog: too long with no beat on either channel ends the run
  // ----------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d result beats still expected", $time,
                 pending_quot_rem.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule : tb_top
